// File: hw/rtl/pe_pkg.sv
`timescale 1ns / 1ps

package pe_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int OUTPUT_WIDTH    = 16;
  localparam int COEFF_FRAC_BITS = 15;
  localparam int COEFF_WIDTH     = 16;
  localparam int BORDER_WIDTH    = 2;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 16;

  // accumulator wide enough for x << frac, the product and the output range
  localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEFF_WIDTH;
  localparam int SHIFT_WIDTH = SAMPLE_WIDTH + COEFF_FRAC_BITS + 1;
  localparam int SPAN_WIDTH  = OUTPUT_WIDTH + COEFF_FRAC_BITS;
  localparam int MAX_A       = (PROD_WIDTH > SHIFT_WIDTH) ? PROD_WIDTH : SHIFT_WIDTH;
  localparam int ACC_WIDTH   = ((MAX_A > SPAN_WIDTH) ? MAX_A : SPAN_WIDTH) + 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COEFF       = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BORDER_MODE = CFG_INDEX_WIDTH'(1);

  localparam logic [BORDER_WIDTH-1:0] BORDER_ZERO    = BORDER_WIDTH'(0);
  localparam logic [BORDER_WIDTH-1:0] BORDER_CLAMP   = BORDER_WIDTH'(1);
  localparam logic [BORDER_WIDTH-1:0] BORDER_REFLECT = BORDER_WIDTH'(2);

  // 0.97 in Q1.15
  localparam logic signed [COEFF_WIDTH-1:0] COEFF_RESET = COEFF_WIDTH'(31785);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [SAMPLE_WIDTH-1:0] b;
    logic                           last;
  } pe_job_t;

endpackage

// File: hw/rtl/pe_mac.sv
`timescale 1ns / 1ps

module pe_mac (
  input  pe_pkg::pe_job_t                         job_i,
  input  logic signed [pe_pkg::COEFF_WIDTH-1:0]   coeff_i,
  output logic signed [pe_pkg::OUTPUT_WIDTH-1:0]  result_o
);
  import pe_pkg::*;

  localparam int Q_WIDTH = ACC_WIDTH - COEFF_FRAC_BITS;
  localparam logic signed [Q_WIDTH-1:0] Q_HI =
    Q_WIDTH'((64'sd1 <<< (OUTPUT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [Q_WIDTH-1:0] Q_LO = ~Q_HI;
  localparam logic signed [ACC_WIDTH-1:0] HALF =
    ACC_WIDTH'(64'sd1 <<< (COEFF_FRAC_BITS - 1));

  logic signed [PROD_WIDTH-1:0]   prod;
  logic signed [ACC_WIDTH-1:0]    x_ext;
  logic signed [ACC_WIDTH-1:0]    prod_ext;
  logic signed [ACC_WIDTH-1:0]    acc;
  logic signed [ACC_WIDTH-1:0]    rnd;
  logic signed [ACC_WIDTH-1:0]    neg_fix;
  logic signed [Q_WIDTH-1:0]      q;

  assign prod     = $signed(job_i.b) * coeff_i;
  assign prod_ext = ACC_WIDTH'(prod);
  assign x_ext    = ACC_WIDTH'($signed(job_i.x)) <<< COEFF_FRAC_BITS;
  assign acc      = x_ext - prod_ext;

  // half away from zero: negative values round with half minus one
  assign neg_fix  = $signed({{(ACC_WIDTH - 1){1'b0}}, acc[ACC_WIDTH-1]});
  assign rnd      = acc + HALF - neg_fix;
  assign q        = $signed(rnd[ACC_WIDTH-1:COEFF_FRAC_BITS]);

  always_comb begin
    if (q > Q_HI) begin
      result_o = Q_HI[OUTPUT_WIDTH-1:0];
    end else if (q < Q_LO) begin
      result_o = Q_LO[OUTPUT_WIDTH-1:0];
    end else begin
      result_o = q[OUTPUT_WIDTH-1:0];
    end
  end

endmodule

// File: hw/rtl/preemphasis_filter.sv
`timescale 1ns / 1ps

// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------
// input    | in_valid_i / in_ready_o   | sample_i, last_i
// output   | out_valid_o / out_ready_i | result_o, result_last_o
// config   | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// one sample per clock while results drain; a job goes through the job stage
// register, then the result register; the second sample of a reflect record
// yields two results, so the single filter datapath holds off the next input
// async active-low reset: record at start, coeff 0.97, border mode clamp
// a stalled result does not block the next input while the job stage is free

module preemphasis_filter (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [pe_pkg::SAMPLE_WIDTH-1:0]      sample_i,
  input  logic                                        last_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic signed [pe_pkg::OUTPUT_WIDTH-1:0]      result_o,
  output logic                                        result_last_o,
  input  logic                                        cfg_we_i,
  input  logic [pe_pkg::CFG_INDEX_WIDTH-1:0]          cfg_index_i,
  input  logic [pe_pkg::CFG_DATA_WIDTH-1:0]           cfg_wdata_i
);
  import pe_pkg::*;

  typedef enum logic [1:0] {
    POS_START,
    POS_INSIDE,
    POS_HELD
  } pos_e;

  pos_e                            pos_q, pos_d;
  logic signed [SAMPLE_WIDTH-1:0]  prev_q;
  logic signed [COEFF_WIDTH-1:0]   coeff_q;
  logic [BORDER_WIDTH-1:0]         border_q;

  logic                            s1_valid_q, s1_valid_d;
  logic                            s1_second_q, s1_second_d;
  pe_job_t                         s1_job_q, s1_job_d;
  pe_job_t                         s1_next_q, s1_next_d;

  logic                            out_valid_q;
  logic signed [OUTPUT_WIDTH-1:0]  result_q;
  logic                            result_last_q;

  logic                            in_acc;
  logic                            out_free;
  logic                            s1_adv;
  logic                            new_valid;
  logic                            new_second;
  pe_job_t                         new_job;
  pe_job_t                         new_next;
  logic signed [OUTPUT_WIDTH-1:0]  mac_result;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || (s1_adv && !s1_second_q);
  assign in_acc     = in_valid_i && in_ready_o;

  // turn one input into zero, one or two filter jobs
  always_comb begin
    new_valid  = 1'b1;
    new_second = 1'b0;
    new_job    = '{x: sample_i, b: prev_q, last: last_i};
    new_next   = '{x: sample_i, b: prev_q, last: last_i};
    pos_d      = last_i ? POS_START : POS_INSIDE;
    case (pos_q)
      POS_START: begin
        if (border_q == BORDER_REFLECT && !last_i) begin
          new_valid = 1'b0;
          pos_d     = POS_HELD;
        end else begin
          new_job.b = (border_q == BORDER_ZERO) ? '0 : sample_i;
        end
      end
      POS_HELD: begin
        new_job    = '{x: prev_q, b: sample_i, last: 1'b0};
        new_second = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_second_d = s1_second_q;
    s1_job_d    = s1_job_q;
    s1_next_d   = s1_next_q;
    if (in_acc) begin
      s1_valid_d  = new_valid;
      s1_second_d = new_second;
      s1_job_d    = new_job;
      s1_next_d   = new_next;
    end else if (s1_adv) begin
      if (s1_second_q) begin
        s1_job_d    = s1_next_q;
        s1_second_d = 1'b0;
      end else begin
        s1_valid_d  = 1'b0;
      end
    end
  end

  pe_mac u_mac (
    .job_i    (s1_job_q),
    .coeff_i  (coeff_q),
    .result_o (mac_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_START;
      prev_q      <= '0;
      coeff_q     <= COEFF_RESET;
      border_q    <= BORDER_CLAMP;
      s1_valid_q  <= 1'b0;
      s1_second_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COEFF:       coeff_q  <= $signed(cfg_wdata_i[COEFF_WIDTH-1:0]);
          REG_BORDER_MODE: border_q <= cfg_wdata_i[BORDER_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        pos_q  <= pos_d;
        prev_q <= sample_i;
      end
      s1_valid_q  <= s1_valid_d;
      s1_second_q <= s1_second_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_job_q  <= s1_job_d;
    s1_next_q <= s1_next_d;
    if (s1_adv) begin
      result_q      <= mac_result;
      result_last_q <= s1_job_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_o      = result_q;
  assign result_last_o = result_last_q;

endmodule

// File: hw/rtl/pe_checker.sv
`timescale 1ns / 1ps

module pe_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_ready_o,
  input logic                                    out_valid_o,
  input logic                                    out_ready_i,
  input logic signed [pe_pkg::OUTPUT_WIDTH-1:0]  result_o,
  input logic                                    result_last_o
);
  import pe_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o)
      && $stable(result_last_o))
    else $error("stalled result changed");

  // output register empty under reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // a result appearing after an empty cycle comes from an item taken into the job stage before it
  a_rise_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a preceding item");

  // no result appears out of an idle block
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && in_ready_o) && !$past(in_valid_i && in_ready_o)
      |=> !out_valid_o)
    else $error("result from idle block");

endmodule

bind preemphasis_filter pe_checker u_pe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_o      (result_o),
  .result_last_o (result_last_o)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import pe_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RUN_LIMIT  = 400000;
  localparam int REPORT_MAX = 10;
  localparam int PHASES     = 15;
  localparam int PHASE_LEN  = 110;
  localparam logic [BORDER_WIDTH-1:0] BORDER_SPARE = BORDER_WIDTH'(3);

  typedef enum logic [1:0] {AT_START, IN_RECORD, HOLDING_FIRST} rec_pos_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } sample_item_t;

  typedef struct packed {
    logic signed [OUTPUT_WIDTH-1:0] value;
    logic                           last;
  } filtered_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [SAMPLE_WIDTH-1:0]    sample_i;
  logic                              last_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [OUTPUT_WIDTH-1:0]    result_o;
  logic                              result_last_o;
  logic                              cfg_we_i;
  logic [CFG_INDEX_WIDTH-1:0]        cfg_index_i;
  logic [CFG_DATA_WIDTH-1:0]         cfg_wdata_i;

  sample_item_t pending_q[$];
  filtered_t    filtered_q[$];
  filtered_t    want;

  logic signed [COEFF_WIDTH-1:0]  mdl_coeff  = COEFF_RESET;
  logic [BORDER_WIDTH-1:0]        mdl_border = BORDER_CLAMP;
  logic signed [SAMPLE_WIDTH-1:0] mdl_prev   = '0;
  rec_pos_e                       mdl_pos    = AT_START;

  logic in_fire;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycle_count   = 0;
  int   error_count   = 0;
  int   checked_count = 0;
  int   sample_count  = 0;
  int   record_count  = 0;

  preemphasis_filter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result_o),
    .result_last_o(result_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // x - coeff * b, rounded half away from zero, saturated
  function automatic logic signed [OUTPUT_WIDTH-1:0] emphasize(
    input logic signed [SAMPLE_WIDTH-1:0] x,
    input logic signed [SAMPLE_WIDTH-1:0] b
  );
    longint acc;
    longint half;
    longint q;
    longint hi;
    longint lo;
    acc  = (longint'(x) <<< COEFF_FRAC_BITS) - longint'(mdl_coeff) * longint'(b);
    half = longint'(1) <<< (COEFF_FRAC_BITS - 1);
    hi   = (longint'(1) <<< (OUTPUT_WIDTH - 1)) - 1;
    lo   = -hi - 1;
    if (acc >= 0) begin
      q = (acc + half) >>> COEFF_FRAC_BITS;
    end else begin
      q = -((-acc + half) >>> COEFF_FRAC_BITS);
    end
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[OUTPUT_WIDTH-1:0];
  endfunction

  task automatic predict_filtered(input sample_item_t it);
    logic signed [SAMPLE_WIDTH-1:0] border_val;
    logic                           held;
    held = 1'b0;
    case (mdl_pos)
      AT_START: begin
        if (mdl_border == BORDER_REFLECT && !it.last) begin
          held = 1'b1;
        end else begin
          border_val = (mdl_border == BORDER_ZERO) ? '0 : it.sample;
          filtered_q.push_back(filtered_t'{emphasize(it.sample, border_val), it.last});
        end
      end
      HOLDING_FIRST: begin
        filtered_q.push_back(filtered_t'{emphasize(mdl_prev, it.sample), 1'b0});
        filtered_q.push_back(filtered_t'{emphasize(it.sample, mdl_prev), it.last});
      end
      default: begin
        filtered_q.push_back(filtered_t'{emphasize(it.sample, mdl_prev), it.last});
      end
    endcase
    mdl_prev = it.sample;
    if (held) begin
      mdl_pos = HOLDING_FIRST;
    end else begin
      mdl_pos = it.last ? AT_START : IN_RECORD;
    end
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(9))
      0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2: return SAMPLE_WIDTH'($urandom_range(8)) - SAMPLE_WIDTH'(4);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic add_sample(input int s, input bit l);
    pending_q.push_back(sample_item_t'{SAMPLE_WIDTH'(s), l});
  endtask

  // records of random length; the phase may cut the last one short
  task automatic queue_records(input int count);
    int k;
    int len;
    int roll;
    k = 0;
    while (k < count) begin
      roll = $urandom_range(19);
      if (roll < 3) begin
        len = 1;
      end else if (roll < 6) begin
        len = 2;
      end else if (roll < 16) begin
        len = $urandom_range(8, 3);
      end else begin
        len = $urandom_range(40, 9);
      end
      for (int j = 0; j < len && k < count; j++) begin
        pending_q.push_back(sample_item_t'{rand_sample(), j == len - 1});
        k++;
      end
    end
  endtask

  // wait until every item is in and every result is out, then let the pipe settle
  task automatic settle();
    do begin
      @(posedge clk_i);
    end while (pending_q.size() != 0 || in_valid_i || filtered_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(
    input logic [CFG_INDEX_WIDTH-1:0] idx,
    input logic [CFG_DATA_WIDTH-1:0]  data
  );
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_COEFF) begin
      mdl_coeff = data;
    end else begin
      mdl_border = data[BORDER_WIDTH-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic write_border(input logic [BORDER_WIDTH-1:0] mode);
    write_reg(REG_BORDER_MODE, {(CFG_DATA_WIDTH-BORDER_WIDTH)'($urandom), mode});
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= pending_q[0].sample;
          last_i     <= pending_q[0].last;
          void'(pending_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predict_filtered(sample_item_t'{sample_i, last_i});
        sample_count++;
        if (last_i) record_count++;
      end
      if (out_valid_o && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("unexpected result %0d last %0b", result_o, result_last_o);
          end
        end else begin
          want = filtered_q.pop_front();
          checked_count++;
          if (result_o !== want.value || result_last_o !== want.last) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
              $display("result mismatch: expected %0d last %0b, got %0d last %0b",
                       want.value, want.last, result_o, result_last_o);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_WIDTH-1:0]  cval;
    logic [BORDER_WIDTH-1:0]    mode;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    last_i      = 1'b0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_COEFF;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    tx_idle_pct = 35;
    rx_idle_pct = 82;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, clamp border
    add_sample(32767, 1'b0);
    add_sample(-32768, 1'b1);
    add_sample(-32768, 1'b0);
    add_sample(32767, 1'b1);
    settle();

    // coefficient -1.0, zero border
    write_reg(REG_COEFF, 16'h8000);
    write_border(BORDER_ZERO);
    add_sample(32767, 1'b0);
    add_sample(-32768, 1'b0);
    add_sample(32767, 1'b1);
    settle();

    // coefficient one half gives exact rounding ties
    write_reg(REG_COEFF, 16'h4000);
    add_sample(1, 1'b0);
    add_sample(0, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(0, 1'b1);
    settle();

    // reflect: normal record, one-sample record, two-sample record, held first
    write_reg(REG_COEFF, 16'h7fff);
    write_border(BORDER_REFLECT);
    add_sample(100, 1'b0);
    add_sample(-200, 1'b0);
    add_sample(300, 1'b1);
    add_sample(12345, 1'b1);
    add_sample(-32768, 1'b0);
    add_sample(32767, 1'b1);
    add_sample(555, 1'b0);
    settle();

    // held sample still finishes as reflect
    write_border(BORDER_ZERO);
    add_sample(777, 1'b1);
    add_sample(1, 1'b0);
    settle();

    // mode change inside a record has no effect on it
    write_border(BORDER_REFLECT);
    add_sample(2, 1'b1);
    settle();

    // spare border code acts as clamp
    write_border(BORDER_SPARE);
    add_sample(1000, 1'b0);
    add_sample(2000, 1'b1);
    add_sample(-5, 1'b1);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        tx_idle_pct = 82;
        rx_idle_pct = 35;
      end
      if (ph == 2 * PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph % 5)
        0: cval = 16'h7fff;
        1: cval = 16'h8000;
        2: cval = COEFF_RESET;
        3: cval = '0;
        default: cval = CFG_DATA_WIDTH'($urandom);
      endcase
      mode = (ph < 12) ? BORDER_WIDTH'(ph % 4) : BORDER_WIDTH'($urandom_range(3));
      if (mode == BORDER_SPARE && ph >= 12) mode = BORDER_REFLECT;
      write_reg(REG_COEFF, cval);
      write_border(mode);
      queue_records(PHASE_LEN);
      settle();
    end

    $display("%0d samples in %0d records sent, %0d filtered results checked",
             sample_count, record_count, checked_count);
    $display("coefficient extremes, all border codes and three idling mixes covered");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
